FILE: rtl/bal_pkg.sv
// Shared definitions for the bounded array list: command and status codes,
// the request and result records and the stream widths.
// No dependencies.
package bal_pkg;

	localparam int CAPACITY_DEF = 8;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_INS_TAIL = 3'd1;
	localparam logic [2:0] CMD_RM_HEAD  = 3'd2;
	localparam logic [2:0] CMD_RM_TAIL  = 3'd3;
	localparam logic [2:0] CMD_RM_VAL   = 3'd4;
	localparam logic [2:0] CMD_SEARCH   = 3'd5;
	localparam logic [2:0] CMD_READ     = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         index;
		logic signed [31:0] value;
		logic [2:0]         cmd;
	} req_t;

	typedef struct packed {
		logic [3:0]         count;
		logic [2:0]         position;
		logic signed [31:0] data;
		logic [1:0]         status;
	} res_t;

endpackage

FILE: rtl/bounded_array_list_core.sv
// Top level of the bounded array list: stream ports, the request register,
// the list storage and the result register.
// Depends on bal_pkg and bal_list.

// Bounded ordered list of signed 32-bit words with head/tail insert and remove,
// remove-by-value, search and indexed read. One command is accepted per clock;
// each gives exactly one result, through the request register and then the
// result register. The whole command, key compare and shift included, is done
// combinationally between those registers, and that path through the compare
// and the entry shift network sets the clock rate. The result register frees in
// the cycle its result is taken. While a result waits untaken, one more request
// can still enter the request register, and after that the input stalls until
// the waiting result leaves. The list updates in the same cycle its result is
// registered, so every command sees all earlier ones. Entry contents are
// undefined after reset but only live entries are ever returned.
module bounded_array_list_core #(
	parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] cmd, [34:3] value, [37:35] index, [39:38] zero
	input  logic [bal_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] status, [33:2] data, [36:34] position, [40:37] count, [47:41] zero
	output logic [bal_pkg::M_TDATA_W-1:0] m_tdata
);
	import bal_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res;
	logic adv;
	logic op_en;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign op_en    = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.cmd   <= s_tdata[2:0];
			req_s1.value <= s_tdata[34:3];
			req_s1.index <= s_tdata[37:35];
		end
		if (op_en) begin
			res_s2 <= res;
		end
	end

	bal_list #(
		.CAPACITY(CAPACITY)
	) u_list (
		.clk   (clk),
		.arst_n(arst_n),
		.op_en (op_en),
		.req   (req_s1),
		.res   (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0000000, res_s2.count, res_s2.position, res_s2.data, res_s2.status};

endmodule

FILE: rtl/bal_list.sv
// List storage of the bounded array list: the entry registers, the fill
// count, the parallel key compare and the shift network for inserts and removes.
// Depends on bal_pkg.
module bal_list #(
	parameter int CAPACITY = bal_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_en,
	input  bal_pkg::req_t req,
	output bal_pkg::res_t res
);
	import bal_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);

	logic signed [31:0] entries_q [CAPACITY];
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      fill_next;

	logic [CAPACITY-1:0] hit;
	logic                found;
	logic [IW-1:0]       hit_pos;
	logic signed [31:0]  hit_data;
	logic signed [31:0]  rd_data;
	logic signed [31:0]  tail_data;
	logic                full;
	logic                empty;
	logic                idx_ok;

	logic               ins_head;
	logic               ins_tail;
	logic               drop_en;
	logic [IW-1:0]      drop_pos;
	logic [1:0]         status;
	logic signed [31:0] data;
	logic [IW-1:0]      pos;
	logic [IW+2:0]      pos_ext;
	logic [FW+3:0]      cnt_ext;

	assign full   = (fill_q == FW'(CAPACITY));
	assign empty  = (fill_q == '0);
	assign idx_ok = ({{FW{1'b0}}, req.index} < {3'b000, fill_q});

	// Compare the key against every live entry at once, then take the lowest hit.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i] = (FW'(i) < fill_q) && (entries_q[i] == req.value);
		end
		found   = |hit;
		hit_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_pos = IW'(i);
			end
		end
	end

	always_comb begin
		hit_data  = '0;
		rd_data   = '0;
		tail_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IW'(i) == hit_pos) begin
				hit_data = entries_q[i];
			end
			if (int'(req.index) == i) begin
				rd_data = entries_q[i];
			end
			if (FW'(i + 1) == fill_q) begin
				tail_data = entries_q[i];
			end
		end
	end

	always_comb begin
		ins_head  = 1'b0;
		ins_tail  = 1'b0;
		drop_en   = 1'b0;
		drop_pos  = '0;
		status    = ST_OK;
		data      = '0;
		pos       = '0;
		fill_next = fill_q;
		case (req.cmd)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ins_head  = (req.cmd == CMD_INS_HEAD);
					ins_tail  = (req.cmd == CMD_INS_TAIL);
					fill_next = fill_q + 1'b1;
				end
			end
			CMD_RM_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					data      = entries_q[0];
					drop_en   = 1'b1;
					fill_next = fill_q - 1'b1;
				end
			end
			CMD_RM_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					data      = tail_data;
					fill_next = fill_q - 1'b1;
				end
			end
			CMD_RM_VAL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOTFOUND;
				end else begin
					data      = hit_data;
					pos       = hit_pos;
					drop_en   = 1'b1;
					drop_pos  = hit_pos;
					fill_next = fill_q - 1'b1;
				end
			end
			CMD_SEARCH: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOTFOUND;
				end else begin
					pos = hit_pos;
				end
			end
			CMD_READ: begin
				if (idx_ok) begin
					data = rd_data;
				end else begin
					status = ST_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Position and count are reported modulo their field widths.
	assign pos_ext      = {3'b000, pos};
	assign cnt_ext      = {4'b0000, fill_next};
	assign res.status   = status;
	assign res.data     = data;
	assign res.position = pos_ext[2:0];
	assign res.count    = cnt_ext[3:0];

	always_ff @(posedge clk) begin
		if (op_en) begin
			if (ins_head) begin
				entries_q[0] <= req.value;
				for (int i = 1; i < CAPACITY; i++) begin
					entries_q[i] <= entries_q[i-1];
				end
			end else if (ins_tail) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (FW'(i) == fill_q) begin
						entries_q[i] <= req.value;
					end
				end
			end else if (drop_en) begin
				// Entries from the removed position on move one place toward the head.
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (IW'(i) >= drop_pos) begin
						entries_q[i] <= entries_q[i+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (op_en) begin
			fill_q <= fill_next;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(CAPACITY))
		else $error("fill count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op_en && (ins_head || ins_tail) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert did not grow the list by one");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		op_en && (status != ST_OK) |=> $stable(fill_q))
		else $error("rejected command changed the fill count");

	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op_en && drop_en |-> !empty && found || op_en && drop_en && req.cmd == CMD_RM_HEAD)
		else $error("removal from an empty list or without a match");
`endif

endmodule
